@@ rtl/lri_pkg.sv @@
// Shared types and constants for the line raster interpolate block.
// Used by lri_ctrl, lri_dp and the top level; depends on nothing.
`default_nettype none

package lri_pkg;

    // Dash pattern: a period of 8 pixels along the major axis, the first 4 drawn
    localparam int DASH_PERIOD_W = 3;
    localparam int DASH_ON       = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_END
    } t_lri_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the end points of an accepted beat
        logic setup;      // pick the major axis, swap, form the spans
        logic step;       // advance one major coordinate
        logic emit;       // load the current walk pixel into the output register
        logic emit_last;  // load the end point pixel, with last set
    } t_lri_cmd;

    // Datapath to controller
    typedef struct packed {
        logic at_end;     // walk has reached the end point
        logic keep;       // current walk pixel lies in a drawn dash
        logic out_free;   // output register can take a pixel this cycle
    } t_lri_sts;

endpackage

`default_nettype wire

@@ rtl/lri_ctrl.sv @@
// Controller state machine for the line raster interpolate block.
// Depends on lri_pkg; drives the datapath lri_dp through t_lri_cmd.
`default_nettype none

module lri_ctrl
    import lri_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_lri_sts i_sts,
    output t_lri_cmd      o_cmd
);

    t_lri_state r_state;
    t_lri_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.at_end) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            S_WALK: begin
                // drop pixels in a dash gap without waiting on the output side
                if (!i_sts.at_end) begin
                    if (!i_sts.keep) begin
                        o_cmd.step = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.step = 1'b1;
                        o_cmd.emit = 1'b1;
                    end
                end
            end
            S_END: begin
                o_cmd.emit_last = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_walk_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.at_end) |=> (r_state == S_END))
        else $error("walk did not close at the end point");

    a_end_emits_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_last |=> (r_state == S_IDLE && !o_cmd.emit_last))
        else $error("end point emitted more than once");

    a_no_step_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step || o_cmd.emit) |-> (r_state == S_WALK && !i_sts.at_end))
        else $error("walk advanced past the end point");

endmodule

`default_nettype wire

@@ rtl/lri_dp.sv @@
// Datapath for the line raster interpolate block: end point registers, the
// incremental minor axis walk, address multiply and output register. Uses lri_pkg.
`default_nettype none

module lri_dp
    import lri_pkg::*;
#(
    parameter int COORD_RANGE = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [$clog2(COORD_RANGE):0]  i_cfg_wr_data,
    input  wire logic [$clog2(COORD_RANGE)-1:0] i_x_start,
    input  wire logic [$clog2(COORD_RANGE)-1:0] i_y_start,
    input  wire logic [$clog2(COORD_RANGE)-1:0] i_x_end,
    input  wire logic [$clog2(COORD_RANGE)-1:0] i_y_end,
    input  wire logic                          i_dashed,
    input  wire t_lri_cmd                      i_cmd,
    output t_lri_sts                           o_sts,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [$clog2(COORD_RANGE)-1:0]     o_pixel_x,
    output logic [$clog2(COORD_RANGE)-1:0]     o_pixel_y,
    output logic [2*$clog2(COORD_RANGE)-1:0]   o_pixel_address,
    output logic                               o_last
);

    localparam int CW = $clog2(COORD_RANGE);
    localparam int WW = CW + 1;
    localparam int AW = 2 * CW;
    localparam int MW = (CW < DASH_PERIOD_W) ? DASH_PERIOD_W : CW;

    logic [WW-1:0] r_width;

    logic [CW-1:0] r_xs, r_ys, r_xe, r_ye;
    logic          r_dashed;

    logic          r_along_x;
    logic          r_neg;
    logic [CW-1:0] r_me, r_ns, r_ne;
    logic [CW-1:0] r_major, r_abs_span;
    logic [CW-1:0] r_m, r_acc, r_q;

    logic          r_out_valid;
    logic [CW-1:0] r_px, r_py;
    logic [AW-1:0] r_addr;
    logic          r_last;

    // setup
    logic [CW-1:0] adx, ady;
    logic          along_x;
    logic [CW-1:0] a_ms, a_me, a_ns, a_ne;
    logic          swap;
    logic [CW-1:0] s_ms, s_me, s_ns, s_ne;

    // walk
    logic [CW:0]   acc_sum;
    logic          wrap;
    logic [CW-1:0] n_acc, n_q;
    logic [CW-1:0] cur_n;
    logic [MW-1:0] m_ext;

    // output
    logic [CW-1:0] sel_x, sel_y;
    logic [AW:0]   prod;
    logic [AW:0]   addr_sum;
    logic          out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WW'(COORD_RANGE);
        end else if (i_cfg_wr_en) begin
            r_width <= i_cfg_wr_data;
        end
    end

    always_comb begin
        adx     = (r_xe > r_xs) ? (r_xe - r_xs) : (r_xs - r_xe);
        ady     = (r_ye > r_ys) ? (r_ye - r_ys) : (r_ys - r_ye);
        along_x = adx > ady;
        a_ms    = along_x ? r_xs : r_ys;
        a_me    = along_x ? r_xe : r_ye;
        a_ns    = along_x ? r_ys : r_xs;
        a_ne    = along_x ? r_ye : r_xe;
        // walk upward along the major axis
        swap    = a_ms > a_me;
        s_ms    = swap ? a_me : a_ms;
        s_me    = swap ? a_ms : a_me;
        s_ns    = swap ? a_ne : a_ns;
        s_ne    = swap ? a_ns : a_ne;
    end

    // Quotient and remainder of offset * |minor span| / major span, kept
    // incrementally; |minor span| <= major span, so one subtract per step.
    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, r_abs_span};
        wrap    = acc_sum >= {1'b0, r_major};
        n_acc   = wrap ? CW'(acc_sum - {1'b0, r_major}) : CW'(acc_sum);
        n_q     = r_q + CW'(wrap);
        // truncation toward zero: negate the magnitude quotient
        cur_n   = r_neg ? (r_ns - r_q) : (r_ns + r_q);
        m_ext   = MW'(r_m);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs     <= i_x_start;
            r_ys     <= i_y_start;
            r_xe     <= i_x_end;
            r_ye     <= i_y_end;
            r_dashed <= i_dashed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= '0;
            r_acc   <= '0;
            r_q     <= '0;
        end else if (i_cmd.setup) begin
            r_major <= s_me - s_ms;
            r_acc   <= '0;
            r_q     <= '0;
        end else if (i_cmd.step) begin
            r_acc   <= n_acc;
            r_q     <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_along_x  <= along_x;
            r_m        <= s_ms;
            r_me       <= s_me;
            r_ns       <= s_ns;
            r_ne       <= s_ne;
            r_neg      <= s_ns > s_ne;
            r_abs_span <= (s_ns > s_ne) ? (s_ns - s_ne) : (s_ne - s_ns);
        end else if (i_cmd.step) begin
            r_m        <= r_m + CW'(1);
        end
    end

    always_comb begin
        if (i_cmd.emit_last) begin
            sel_x = r_along_x ? r_me : r_ne;
            sel_y = r_along_x ? r_ne : r_me;
        end else begin
            sel_x = r_along_x ? r_m : cur_n;
            sel_y = r_along_x ? cur_n : r_m;
        end
        prod     = (AW+1)'(sel_y) * (AW+1)'(r_width);
        addr_sum = prod + (AW+1)'(sel_x);
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit || i_cmd.emit_last) begin
            r_px   <= sel_x;
            r_py   <= sel_y;
            r_addr <= addr_sum[AW-1:0];
            r_last <= i_cmd.emit_last;
        end
    end

    assign o_sts.at_end     = r_m == r_me;
    assign o_sts.keep       = !r_dashed || (m_ext[DASH_PERIOD_W-1:0] < DASH_PERIOD_W'(DASH_ON));
    assign o_sts.out_free   = out_free;

    assign o_out_valid      = r_out_valid;
    assign o_pixel_x        = r_px;
    assign o_pixel_y        = r_py;
    assign o_pixel_address  = r_addr;
    assign o_last           = r_last;

    a_rem_below_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_major != '0) |-> (r_acc < r_major))
        else $error("walk remainder reached the major span");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_last) |-> out_free)
        else $error("pixel loaded over an untaken beat");

    a_quot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_q <= r_abs_span))
        else $error("minor offset overran the minor span");

endmodule

`default_nettype wire

@@ rtl/line_raster_interpolate_unit.sv @@
// Line raster interpolate unit: one line request in, a run of pixel beats out.
// Top level; instantiates lri_ctrl and lri_dp, uses lri_pkg.
//
// Each input beat carries two end points and a dash flag; the unit returns the
// pixels of the line along its major axis (ties go to y), each with column,
// row and linear address row * image_width + column (wrapped to the address
// width), and closes the run with the end point, marked by tlast. A dashed
// line draws only pixels whose major coordinate mod 8 is below 4; the end
// point is always drawn. A line is accepted, then the axis is picked and the
// ends swapped, then the walk steps along the major axis one coordinate at a
// time (a dropped dash pixel takes a step too, but a kept pixel waits for the
// output side), then the end point is seen reached and is emitted once the
// output side is free. The walk forms the minor coordinate with one add and
// compare per step. Lines are handled one at a time; the next request is
// taken as soon as the end point sits in the output register.
`default_nettype none

module line_raster_interpolate_unit
    import lri_pkg::*;
#(
    parameter int COORD_RANGE = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // image_width
    input  wire logic                                    i_cfg_wr_en,
    input  wire logic [$clog2(COORD_RANGE):0]            i_cfg_wr_data,
    // request stream
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // x_start, y_start, x_end, y_end from the lowest bit up, zero padded
    input  wire logic [((4*$clog2(COORD_RANGE)+7)/8)*8-1:0] s_axis_tdata,
    // dashed
    input  wire logic                                    s_axis_tuser,
    // pixel stream
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // pixel_x, pixel_y, pixel_address from the lowest bit up, zero padded
    output logic [((4*$clog2(COORD_RANGE)+7)/8)*8-1:0]   m_axis_tdata,
    output logic                                         m_axis_tlast
);

    localparam int CW    = $clog2(COORD_RANGE);
    localparam int AW    = 2 * CW;
    localparam int DW    = ((4 * CW + 7) / 8) * 8;

    t_lri_cmd      cmd;
    t_lri_sts      sts;
    logic [CW-1:0] pixel_x, pixel_y;
    logic [AW-1:0] pixel_address;

    lri_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lri_dp #(
        .COORD_RANGE (COORD_RANGE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_x_start       (s_axis_tdata[CW-1:0]),
        .i_y_start       (s_axis_tdata[2*CW-1:CW]),
        .i_x_end         (s_axis_tdata[3*CW-1:2*CW]),
        .i_y_end         (s_axis_tdata[4*CW-1:3*CW]),
        .i_dashed        (s_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_pixel_x       (pixel_x),
        .o_pixel_y       (pixel_y),
        .o_pixel_address (pixel_address),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = DW'({pixel_address, pixel_y, pixel_x});

endmodule

`default_nettype wire
